### rtl/fgt_pkg.sv
// Shared types and single-precision arithmetic for the 4x4 float tile MAC.
// Holds the request/tile types and the multiply, add and rounding functions.
// No dependencies.
package fgt_pkg;

   localparam int TileDim  = 4;
   localparam int TileSize = 16;
   localparam int QDepth   = 2;
   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   typedef struct packed {
      logic       last;
      logic [2:0] rows;
      logic [2:0] cols;
   } ctl_type;

   typedef struct packed {
      logic [TileDim-1:0][31:0] a;
      logic [TileDim-1:0][31:0] b;
      ctl_type                  ctl;
   } item_type;

   typedef struct packed {
      logic               sgn;
      logic               nan;
      logic               inf;
      logic signed [10:0] e;
      logic [47:0]        p;
   } mprod_type;

   typedef logic [TileDim-1:0][TileDim-1:0][31:0] tile_type;

   function automatic logic [6:0] lzc65(input logic [64:0] v);
      logic [6:0] n;
      n = 7'd65;
      for (int i = 0; i < 65; i++) begin
         if (v[i]) n = 7'(64 - i);
      end
      return n;
   endfunction

   // round a value with its leading one at bit 64 to single, nearest even
   function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                            input logic [64:0] n);
      logic [64:0] m;
      logic        stk;
      logic [7:0]  ef;
      logic        up;
      logic [24:0] k;
      logic [30:0] mag;
      logic [7:0]  sh;
      m   = n;
      stk = 1'b0;
      ef  = 8'd0;
      sh  = 8'd0;
      if (e >= 11'sd255) return {s, 8'hFF, 23'd0};
      if (e <= 11'sd0) begin
         sh = 8'(11'sd1 - e);
         if (sh >= 8'd65) begin
            stk = |m;
            m   = '0;
         end else begin
            stk = |(m & ((65'd1 << sh) - 65'd1));
            m   = m >> sh;
         end
         ef = 8'd1;
      end else begin
         ef = e[7:0];
      end
      up  = m[40] & (stk | (|m[39:0]) | m[41]);
      k   = {1'b0, m[64:41]} + 25'(up);
      mag = {ef - 8'd1, 23'd0} + 31'(k);
      return {s, mag};
   endfunction

   function automatic mprod_type fp_mul_pre(input logic [31:0] x, input logic [31:0] y);
      mprod_type r;
      logic [7:0] ex, ey;
      logic       nx, ny, ix, iy, zx, zy;
      ex = x[30:23];
      ey = y[30:23];
      nx = (ex == 8'hFF) && (x[22:0] != 23'd0);
      ny = (ey == 8'hFF) && (y[22:0] != 23'd0);
      ix = (ex == 8'hFF) && (x[22:0] == 23'd0);
      iy = (ey == 8'hFF) && (y[22:0] == 23'd0);
      zx = (x[30:0] == 31'd0);
      zy = (y[30:0] == 31'd0);
      r.sgn = x[31] ^ y[31];
      r.nan = nx | ny | (ix & zy) | (iy & zx);
      r.inf = ix | iy;
      r.p   = {ex != 8'd0, x[22:0]} * {ey != 8'd0, y[22:0]};
      r.e   = $signed({3'd0, (ex == 8'd0) ? 8'd1 : ex})
            + $signed({3'd0, (ey == 8'd0) ? 8'd1 : ey}) - 11'sd127;
      return r;
   endfunction

   function automatic logic [31:0] fp_mul_fin(input mprod_type m);
      logic [64:0]        n;
      logic [6:0]         lz;
      logic signed [10:0] e;
      n  = {m.p, 17'd0};
      lz = lzc65(n);
      e  = m.e + 11'sd1 - $signed({4'd0, lz});
      if (m.nan) return QNAN;
      if (m.inf) return {m.sgn, 8'hFF, 23'd0};
      if (m.p == 48'd0) return {m.sgn, 31'd0};
      return fp_round(m.sgn, e, n << lz);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
      logic [7:0]  ex, ey, ea, eb;
      logic [23:0] mx, my, ma, mb;
      logic        nx, ny, ix, iy, sa, sb, st, swap;
      logic [7:0]  d;
      logic [63:0] bw;
      logic [64:0] av, bv, s;
      logic [6:0]  lz;
      logic signed [10:0] e;
      ex = x[30:23];
      ey = y[30:23];
      nx = (ex == 8'hFF) && (x[22:0] != 23'd0);
      ny = (ey == 8'hFF) && (y[22:0] != 23'd0);
      ix = (ex == 8'hFF) && (x[22:0] == 23'd0);
      iy = (ey == 8'hFF) && (y[22:0] == 23'd0);
      mx = {ex != 8'd0, x[22:0]};
      my = {ey != 8'd0, y[22:0]};
      if (ex == 8'd0) ex = 8'd1;
      if (ey == 8'd0) ey = 8'd1;
      swap = {ey, my} > {ex, mx};
      sa = swap ? y[31] : x[31];
      sb = swap ? x[31] : y[31];
      ea = swap ? ey : ex;
      eb = swap ? ex : ey;
      ma = swap ? my : mx;
      mb = swap ? mx : my;
      d  = ea - eb;
      if (d >= 8'd64) begin
         bw = '0;
         st = |mb;
      end else begin
         bw = {mb, 40'd0} >> d;
         st = |({mb, 40'd0} & ((64'd1 << d) - 64'd1));
      end
      av = {1'b0, ma, 40'd0};
      bv = {1'b0, bw} | 65'(st);
      s  = (sa == sb) ? av + bv : av - bv;
      lz = lzc65(s);
      e  = $signed({3'd0, ea}) + 11'sd1 - $signed({4'd0, lz});
      if (nx | ny | (ix & iy & (x[31] != y[31]))) return QNAN;
      if (ix) return x;
      if (iy) return y;
      if (s == 65'd0) return {sa & sb, 31'd0};
      return fp_round(sa, e, s << lz);
   endfunction

   function automatic logic [31:0] fp_canon(input logic [31:0] v);
      if ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) return QNAN;
      return v;
   endfunction

   function automatic logic [2:0] sat4(input logic [2:0] v);
      return (v > 3'd4) ? 3'd4 : v;
   endfunction

endpackage

### rtl/fgt_front.sv
// Front end: takes requests, saturates row/column counts, queues them.
// Depends on fgt_pkg.
module fgt_front import fgt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_a_row0,
   input  logic [31:0] req_a_row1,
   input  logic [31:0] req_a_row2,
   input  logic [31:0] req_a_row3,
   input  logic [31:0] req_b_col0,
   input  logic [31:0] req_b_col1,
   input  logic [31:0] req_b_col2,
   input  logic [31:0] req_b_col3,
   input  logic        req_last_step,
   input  logic [2:0]  req_valid_rows,
   input  logic [2:0]  req_valid_cols,
   output logic        head_valid,
   output item_type    head,
   input  logic        pop
);

   item_type   q_ff [QDepth];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   it;
   logic       push;

   always_comb begin
      it.a        = {req_a_row3, req_a_row2, req_a_row1, req_a_row0};
      it.b        = {req_b_col3, req_b_col2, req_b_col1, req_b_col0};
      it.ctl.last = req_last_step;
      it.ctl.rows = sat4(req_valid_rows);
      it.ctl.cols = sat4(req_valid_cols);
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= it;
   end

endmodule

### rtl/fgt_back.sv
// Back end: two-stage float multiply of the sixteen products, then accumulate.
// On the last step, hands the tile to the emitter if rows > 0. Depends on fgt_pkg.
module fgt_back import fgt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  item_type head,
   output logic     pop,
   input  logic     emit_ready,
   output logic     load,
   output ctl_type  load_ctl,
   output tile_type load_tile
);

   mprod_type [TileSize-1:0]       mp_ff, mp_in;
   logic      [TileSize-1:0][31:0] pr_ff, pr_in;
   logic      [TileSize-1:0][31:0] acc_ff, acc_in;
   ctl_type   c1_ff, c2_ff;
   logic      v1_ff, v2_ff;
   logic      hold, adv;

   assign hold = v2_ff && c2_ff.last && (c2_ff.rows != 3'd0) && !emit_ready;
   assign adv  = !hold;
   assign pop  = head_valid && adv;

   always_comb begin
      for (int r = 0; r < TileDim; r++) begin
         for (int c = 0; c < TileDim; c++) begin
            mp_in[r*TileDim+c] = fp_mul_pre(head.a[r], head.b[c]);
         end
      end
      for (int i = 0; i < TileSize; i++) begin
         pr_in[i]  = fp_mul_fin(mp_ff[i]);
         acc_in[i] = fp_add(acc_ff[i], pr_ff[i]);
      end
   end

   assign load      = adv && v2_ff && c2_ff.last && (c2_ff.rows != 3'd0);
   assign load_ctl  = c2_ff;
   assign load_tile = tile_type'(acc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else if (adv) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         if (v2_ff) acc_ff <= c2_ff.last ? '0 : acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mp_ff <= mp_in;
         c1_ff <= head.ctl;
         pr_ff <= pr_in;
         c2_ff <= c1_ff;
      end
   end

endmodule

### rtl/fgt_emit.sv
// Row emitter: holds a finished tile and presents it one row per response.
// Depends on fgt_pkg.
module fgt_emit import fgt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  ctl_type     load_ctl,
   input  tile_type    load_tile,
   output logic        emit_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_row_index,
   output logic [31:0] rsp_sum_col0,
   output logic [31:0] rsp_sum_col1,
   output logic [31:0] rsp_sum_col2,
   output logic [31:0] rsp_sum_col3,
   output logic [2:0]  rsp_cols_in_use,
   output logic        rsp_last_row
);

   tile_type   buf_ff;
   logic [2:0] rows_ff, cols_ff;
   logic [1:0] row_ff;
   logic       busy_ff;
   logic       fire, done;

   assign rsp_valid       = busy_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_sum_col0    = fp_canon(buf_ff[0][0]);
   assign rsp_sum_col1    = fp_canon(buf_ff[0][1]);
   assign rsp_sum_col2    = fp_canon(buf_ff[0][2]);
   assign rsp_sum_col3    = fp_canon(buf_ff[0][3]);
   assign rsp_cols_in_use = cols_ff;
   assign rsp_last_row    = ({1'b0, row_ff} + 3'd1 == rows_ff);
   assign fire            = rsp_valid && rsp_ready;
   assign done            = fire && rsp_last_row;
   assign emit_ready      = !busy_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff  <= load_tile;
         rows_ff <= load_ctl.rows;
         cols_ff <= load_ctl.cols;
         row_ff  <= 2'd0;
      end else if (fire) begin
         for (int r = 0; r < TileDim - 1; r++) begin
            buf_ff[r] <= buf_ff[r+1];
         end
         row_ff <= row_ff + 2'd1;
      end
   end

endmodule

### rtl/float_gemm_4x4_tile_mac_core.sv
// 4x4 single-precision outer-product MAC tile, top level.
// Takes one inner-dimension step per cycle unless the emitter stalls; the 16-lane accumulate
// stage sets this pace. Rows then leave at one per cycle while rsp_ready is high.
// A new tile's last step waits in the accumulate stage until the previous tile has drained.
// Synchronous active-high reset empties the queue and pipeline and zeroes the tile.
// Depends on fgt_pkg, fgt_front, fgt_back, fgt_emit.
module float_gemm_4x4_tile_mac_core import fgt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_a_row0,
   input  logic [31:0] req_a_row1,
   input  logic [31:0] req_a_row2,
   input  logic [31:0] req_a_row3,
   input  logic [31:0] req_b_col0,
   input  logic [31:0] req_b_col1,
   input  logic [31:0] req_b_col2,
   input  logic [31:0] req_b_col3,
   input  logic        req_last_step,
   input  logic [2:0]  req_valid_rows,
   input  logic [2:0]  req_valid_cols,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_row_index,
   output logic [31:0] rsp_sum_col0,
   output logic [31:0] rsp_sum_col1,
   output logic [31:0] rsp_sum_col2,
   output logic [31:0] rsp_sum_col3,
   output logic [2:0]  rsp_cols_in_use,
   output logic        rsp_last_row
);

   logic     head_valid, pop, emit_ready, load;
   item_type head;
   ctl_type  load_ctl;
   tile_type load_tile;

   fgt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_a_row0     (req_a_row0),
      .req_a_row1     (req_a_row1),
      .req_a_row2     (req_a_row2),
      .req_a_row3     (req_a_row3),
      .req_b_col0     (req_b_col0),
      .req_b_col1     (req_b_col1),
      .req_b_col2     (req_b_col2),
      .req_b_col3     (req_b_col3),
      .req_last_step  (req_last_step),
      .req_valid_rows (req_valid_rows),
      .req_valid_cols (req_valid_cols),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop)
   );

   fgt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .emit_ready (emit_ready),
      .load       (load),
      .load_ctl   (load_ctl),
      .load_tile  (load_tile)
   );

   fgt_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .load_ctl        (load_ctl),
      .load_tile       (load_tile),
      .emit_ready      (emit_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_index   (rsp_row_index),
      .rsp_sum_col0    (rsp_sum_col0),
      .rsp_sum_col1    (rsp_sum_col1),
      .rsp_sum_col2    (rsp_sum_col2),
      .rsp_sum_col3    (rsp_sum_col3),
      .rsp_cols_in_use (rsp_cols_in_use),
      .rsp_last_row    (rsp_last_row)
   );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the 4x4 single-precision outer-product MAC tile.
// Predicts every emitted tile row with bit-exact integer float arithmetic.
// Depends on fgt_pkg and float_gemm_4x4_tile_mac_core.
module tb_top;
   import fgt_pkg::*;

   localparam int CycleLimit = 400000;
   localparam logic [31:0] PosInf = 32'h7F80_0000;
   localparam logic [31:0] NegInf = 32'hFF80_0000;
   localparam logic [31:0] MaxFin = 32'h7F7F_FFFF;
   localparam logic [31:0] MinSub = 32'h0000_0001;
   localparam logic [31:0] SigNan = 32'h7F80_0001;
   localparam logic [31:0] OneF   = 32'h3F80_0000;

   typedef struct {
      logic [1:0]  row;
      logic [31:0] sums [4];
      logic [2:0]  cols;
      logic        last_row;
   } row_sums_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] a_in [4];
   logic [31:0] b_in [4];
   logic        req_last_step = 1'b0;
   logic [2:0]  req_valid_rows = 3'd0;
   logic [2:0]  req_valid_cols = 3'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_row_index;
   logic [31:0] rsp_sum_col0, rsp_sum_col1, rsp_sum_col2, rsp_sum_col3;
   logic [2:0]  rsp_cols_in_use;
   logic        rsp_last_row;

   logic [31:0]  tile_acc [16];
   row_sums_type pending_rows [$];
   int           errors = 0;
   int           steps_sent = 0;
   int           rows_checked = 0;
   int           cycles = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   float_gemm_4x4_tile_mac_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_row0(a_in[0]), .req_a_row1(a_in[1]), .req_a_row2(a_in[2]), .req_a_row3(a_in[3]),
      .req_b_col0(b_in[0]), .req_b_col1(b_in[1]), .req_b_col2(b_in[2]), .req_b_col3(b_in[3]),
      .req_last_step(req_last_step), .req_valid_rows(req_valid_rows),
      .req_valid_cols(req_valid_cols),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_row_index(rsp_row_index),
      .rsp_sum_col0(rsp_sum_col0), .rsp_sum_col1(rsp_sum_col1),
      .rsp_sum_col2(rsp_sum_col2), .rsp_sum_col3(rsp_sum_col3),
      .rsp_cols_in_use(rsp_cols_in_use), .rsp_last_row(rsp_last_row)
   );

   initial begin
      for (int i = 0; i < 4; i++) begin
         a_in[i] = '0;
         b_in[i] = '0;
      end
      for (int i = 0; i < 16; i++) tile_acc[i] = '0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   function automatic logic [23:0] sig_of(input logic [31:0] v);
      return {v[30:23] != 8'd0, v[22:0]};
   endfunction

   function automatic int lsb_exp(input logic [31:0] v);
      return ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150;
   endfunction

   // round m * 2^e to single, nearest even
   function automatic logic [31:0] f32_round(input logic s, input int e, input logic [127:0] m);
      int          msb, sh, bexp;
      logic [127:0] q;
      logic        g, rest;
      msb = 0;
      if (m == '0) return {s, 31'd0};
      for (int i = 0; i < 128; i++) if (m[i]) msb = i;
      sh = msb - 23;
      if (sh < -149 - e) sh = -149 - e;
      if (sh > 0) begin
         q    = m >> sh;
         g    = 1'((m >> (sh - 1)) & 128'd1);
         rest = |(m & ((128'd1 << (sh - 1)) - 128'd1));
         if (g && (rest || q[0])) q = q + 128'd1;
      end else begin
         q = m << (-sh);
      end
      if (q[24]) begin
         q  = q >> 1;
         sh = sh + 1;
      end
      bexp = q[23] ? e + sh + 150 : 0;
      if (bexp >= 255) return {s, 8'hFF, 23'd0};
      return {s, bexp[7:0], q[22:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] x, input logic [31:0] y);
      logic s;
      logic [127:0] m;
      s = x[31] ^ y[31];
      if (is_nan(x) || is_nan(y)) return QNAN;
      if ((is_inf(x) && y[30:0] == 31'd0) || (is_inf(y) && x[30:0] == 31'd0)) return QNAN;
      if (is_inf(x) || is_inf(y)) return {s, 8'hFF, 23'd0};
      m = 128'(sig_of(x)) * 128'(sig_of(y));
      if (m == '0) return {s, 31'd0};
      return f32_round(s, lsb_exp(x) + lsb_exp(y), m);
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] x, input logic [31:0] y);
      logic [31:0]  hi, lo;
      logic [127:0] ma, mb, m;
      logic         s;
      int           d;
      if (is_nan(x) || is_nan(y)) return QNAN;
      if (is_inf(x) && is_inf(y) && (x[31] != y[31])) return QNAN;
      if (is_inf(x)) return x;
      if (is_inf(y)) return y;
      if (lsb_exp(x) >= lsb_exp(y)) begin
         hi = x;
         lo = y;
      end else begin
         hi = y;
         lo = x;
      end
      d  = lsb_exp(hi) - lsb_exp(lo);
      ma = 128'(sig_of(hi)) << 90;
      if (d <= 90) mb = 128'(sig_of(lo)) << (90 - d);
      else mb = (sig_of(lo) != 24'd0) ? 128'd1 : 128'd0;
      if (hi[31] == lo[31]) begin
         m = ma + mb;
         s = hi[31];
      end else if (ma >= mb) begin
         m = ma - mb;
         s = hi[31];
      end else begin
         m = mb - ma;
         s = lo[31];
      end
      if (m == '0) return {hi[31] & lo[31], 31'd0};
      return f32_round(s, lsb_exp(hi) - 90, m);
   endfunction

   task automatic accumulate_step(input logic [31:0] av [4], input logic [31:0] bv [4],
                                  input logic last, input logic [2:0] rows_in,
                                  input logic [2:0] cols_in);
      row_sums_type r;
      int           nrows;
      logic [2:0]   ncols;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            tile_acc[i*4+j] = f32_add(tile_acc[i*4+j], f32_mul(av[i], bv[j]));
      if (!last) return;
      nrows = (rows_in > 3'd4) ? 4 : int'(rows_in);
      ncols = (cols_in > 3'd4) ? 3'd4 : cols_in;
      for (int i = 0; i < nrows; i++) begin
         r.row = 2'(i);
         for (int j = 0; j < 4; j++)
            r.sums[j] = is_nan(tile_acc[i*4+j]) ? QNAN : tile_acc[i*4+j];
         r.cols     = ncols;
         r.last_row = (i == nrows - 1);
         pending_rows.push_back(r);
      end
      for (int i = 0; i < 16; i++) tile_acc[i] = '0;
   endtask

   task automatic send_step(input logic [31:0] av [4], input logic [31:0] bv [4],
                            input logic last, input logic [2:0] rows_in,
                            input logic [2:0] cols_in);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid      = 1'b1;
      a_in           = av;
      b_in           = bv;
      req_last_step  = last;
      req_valid_rows = rows_in;
      req_valid_cols = cols_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_step(av, bv, last, rows_in, cols_in);
      steps_sent++;
      fork
         begin
            @(negedge clock);
         end
      join_none
   endtask

   task automatic release_bus();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drain();
      release_bus();
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_float();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0: v = {v[31], 8'd0, v[22:0]};
         1: v = {v[31], 8'hFF, ($urandom_range(3) == 0) ? v[22:0] : 23'd0};
         2: v = v;
         default: v = {v[31], 8'(8'd112 + $urandom_range(30)), v[22:0]};
      endcase
      return v;
   endfunction

   task automatic send_rand_step(input logic last, input logic [2:0] rows_in,
                                 input logic [2:0] cols_in);
      logic [31:0] av [4];
      logic [31:0] bv [4];
      for (int i = 0; i < 4; i++) begin
         av[i] = rand_float();
         bv[i] = rand_float();
      end
      send_step(av, bv, last, rows_in, cols_in);
   endtask

   task automatic test_directed();
      logic [31:0] av [4];
      logic [31:0] bv [4];
      av = '{32'h0, 32'hFFFF_FFFF, MinSub, MaxFin};
      bv = '{32'h8000_0000, OneF, MaxFin, 32'h0000_0000};
      send_step(av, bv, 1'b0, 3'd7, 3'd0);
      av = '{PosInf, NegInf, SigNan, 32'h0080_0000};
      bv = '{32'h0, PosInf, OneF, 32'h3F00_0000};
      send_step(av, bv, 1'b1, 3'd4, 3'd4);
      av = '{MaxFin, MaxFin, 32'h007F_FFFF, MinSub};
      bv = '{MaxFin, 32'hFF7F_FFFF, 32'h3F80_0001, 32'h3F00_0000};
      send_step(av, bv, 1'b1, 3'd7, 3'd7);
      av = '{PosInf, OneF, OneF, OneF};
      bv = '{OneF, OneF, OneF, OneF};
      send_step(av, bv, 1'b0, 3'd0, 3'd0);
      av = '{NegInf, 32'hBF80_0000, OneF, OneF};
      send_step(av, bv, 1'b1, 3'd1, 3'd1);
      av = '{OneF, OneF, OneF, OneF};
      send_step(av, bv, 1'b1, 3'd0, 3'd2);
      send_step(av, bv, 1'b1, 3'd2, 3'd3);
      bv = '{32'h3380_0000, 32'hB380_0000, 32'h0000_0003, 32'h8000_0001};
      send_step(av, bv, 1'b0, 3'd0, 3'd0);
      send_step(av, bv, 1'b1, 3'd3, 3'd5);
      send_step(av, bv, 1'b1, 3'd5, 3'd6);
      wait_drain();
   endtask

   task automatic test_random_tiles(input int sp, input int rp, input int nsteps);
      int left, len;
      logic [2:0] rr, cc;
      send_idle_pct = sp;
      recv_idle_pct = rp;
      left = nsteps;
      while (left > 0) begin
         len = $urandom_range(5, 1);
         if ($urandom_range(9) == 0) begin
            send_rand_step(1'($urandom_range(1)), 3'($urandom), 3'($urandom));
            left--;
         end else begin
            for (int k = 1; k < len; k++) send_rand_step(1'b0, 3'($urandom), 3'($urandom));
            rr = ($urandom_range(4) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
            cc = ($urandom_range(4) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
            send_rand_step(1'b1, rr, cc);
            left -= len;
         end
      end
      wait_drain();
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      row_sums_type e;
      logic [31:0]  got [4];
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb_top: FAIL");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_sum_col0, rsp_sum_col1, rsp_sum_col2, rsp_sum_col3};
         if (pending_rows.size() == 0) begin
            $display("%0t unexpected row %0d", $realtime, rsp_row_index);
            errors++;
         end else begin
            e = pending_rows.pop_front();
            rows_checked++;
            if (rsp_row_index !== e.row) begin
               $display("%0t row_index exp %0d got %0d", $realtime, e.row, rsp_row_index);
               errors++;
            end
            for (int j = 0; j < 4; j++)
               if (got[j] !== e.sums[j]) begin
                  $display("%0t row %0d sum_col%0d exp %h got %h", $realtime, e.row, j,
                           e.sums[j], got[j]);
                  errors++;
               end
            if (rsp_cols_in_use !== e.cols) begin
               $display("%0t cols_in_use exp %0d got %0d", $realtime, e.cols, rsp_cols_in_use);
               errors++;
            end
            if (rsp_last_row !== e.last_row) begin
               $display("%0t last_row exp %0d got %0d", $realtime, e.last_row, rsp_last_row);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_tiles(38, 71, 40);
      test_random_tiles(71, 38, 40);
      test_random_tiles(0, 0, 40);
      $display("Covered %0d steps and %0d tile rows: specials, edge tiles, idle mixes.",
               steps_sent, rows_checked);
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
